// File: hdl/lms_pkg.sv
// Shared types, codes and sizes for the last-man-standing quorum vote block.
`default_nettype none
package lms_pkg;

  localparam int MaxClients = 16;
  localparam int MaxMembers = 16;
  localparam int SlotW      = $clog2(MaxClients);
  localparam int PosW       = $clog2(MaxMembers);
  localparam int CntW       = $clog2(MaxMembers + 1);
  localparam int JW         = $clog2(MaxClients + 1);
  localparam int ScoreW     = $clog2(2 * MaxClients + 1);
  localparam int SizeW      = $clog2(MaxClients + 1);

  // item kinds
  typedef enum logic [1:0] {
    OP_CLIENT = 2'd0,
    OP_MEMBER = 2'd1,
    OP_DECIDE = 2'd2
  } op_e;

  // vote codes; NEW only lives in the last-vote table
  typedef enum logic [1:0] {
    VOTE_ACK  = 2'd0,
    VOTE_NACK = 2'd1,
    VOTE_WAIT = 2'd2,
    VOTE_NEW  = 2'd3
  } vote_e;

  typedef enum logic [1:0] {
    HEUR_UNDEF = 2'd0,
    HEUR_PASS  = 2'd1,
    HEUR_FAIL  = 2'd2,
    HEUR_RSVD  = 2'd3
  } heur_e;

  typedef enum logic [1:0] {
    TB_LOWEST    = 2'd0,
    TB_HIGHEST   = 2'd1,
    TB_NOMINATED = 2'd2,
    TB_NONE      = 2'd3
  } tb_mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ME_RD,
    ST_ME_LAT,
    ST_PD_SEL,
    ST_PD_LAT,
    ST_PD_M1,
    ST_PD_M1C,
    ST_PD_M2,
    ST_PD_M2C,
    ST_PB_INIT,
    ST_PB_SEL,
    ST_PB_LAT,
    ST_PB_ISEL,
    ST_PB_ILAT,
    ST_PB_DONE,
    ST_NC_SEL,
    ST_NC_LAT,
    ST_UM_SCAN,
    ST_UM_DONE,
    ST_WIN_RD,
    ST_WIN_LAT,
    ST_TB,
    ST_TB_SEL,
    ST_TB_LAT,
    ST_TB_END,
    ST_FIN
  } state_e;

  // one client record as held in the client table
  typedef struct packed {
    logic [31:0] node;
    logic [31:0] ring_node;
    logic [63:0] ring_seq;
    logic [1:0]  heur;
    logic [1:0]  tb_mode;
    logic [31:0] tb_node;
  } client_t;

  localparam int ClientW = $bits(client_t);

endpackage
`default_nettype wire

// File: hdl/last_man_standing_quorum_vote.sv
// Top level: client table, membership RAM and the vote sequencer.
//
//  channel  | dir | tdata (low bit up)                                   | tuser
//  s_axis   | in  | slot, used, node_id, ring_node, ring_seq, heuristic, | op
//           |     | tiebreak_mode, tiebreak_node, member_count,          |
//           |     | member_pos, member_id (216 bits, zero filled)        |
//  m_axis   | out | vote, vote_slot (8 bits, zero filled)                | -
//
// Write items go straight into the tables. A decide item runs a sequencer over the client
// RAM and the membership RAM: a peer scan, a partition build, then the choice of vote.
// Reset clears used flags, member counts and sets last votes to new at once.
// A finished vote waits in the output register; the next item is accepted
// meanwhile, and a later vote holds in its final state until that slot frees.
`default_nettype none
module last_man_standing_quorum_vote (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot, used, node_id, ring_node, ring_seq, heuristic, tiebreak_mode,
  // tiebreak_node, member_count, member_pos, member_id
  input  wire logic [215:0] s_axis_tdata,
  // op
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // vote, vote_slot
  output logic [7:0]        m_axis_tdata
);
  import lms_pkg::*;

  // input fields
  logic [SlotW-1:0] in_slot;
  logic             in_used;
  client_t          in_rec;
  logic [4:0]       in_cnt;
  logic [PosW-1:0]  in_pos;
  logic [31:0]      in_mid;
  logic             accept;

  assign in_slot            = s_axis_tdata[3:0];
  assign in_used            = s_axis_tdata[4];
  assign in_rec.node        = s_axis_tdata[36:5];
  assign in_rec.ring_node   = s_axis_tdata[68:37];
  assign in_rec.ring_seq    = s_axis_tdata[132:69];
  assign in_rec.heur        = s_axis_tdata[134:133];
  assign in_rec.tb_mode     = s_axis_tdata[136:135];
  assign in_rec.tb_node     = s_axis_tdata[168:137];
  assign in_cnt             = s_axis_tdata[173:169];
  assign in_pos             = s_axis_tdata[177:174];
  assign in_mid             = s_axis_tdata[209:178];
  assign accept             = s_axis_tvalid && s_axis_tready;

  // control state
  state_e                state_q, state_d;
  logic [MaxClients-1:0] used_q, used_d;
  logic [CntW-1:0]       cnt_q [MaxClients];
  logic [CntW-1:0]       cnt_d [MaxClients];
  vote_e                 lastv_q [MaxClients];
  vote_e                 lastv_d [MaxClients];
  logic                  out_valid_q, out_valid_d;

  // working registers
  logic [SlotW-1:0]      me_q, me_d;
  logic [CntW-1:0]       me_cnt_q, me_cnt_d;
  vote_e                 me_lv_q, me_lv_d;
  client_t               me_rec_q, me_rec_d;
  logic [JW-1:0]         j_q, j_d, i_q, i_d;
  logic [CntW-1:0]       k_q, k_d;
  logic [JW-1:0]         n_q, n_d;
  logic [31:0]           j_node_q, j_node_d;
  logic [31:0]           j_rnode_q, j_rnode_d;
  logic [63:0]           j_rseq_q, j_rseq_d;
  logic [1:0]            j_heur_q, j_heur_d;
  logic [MaxClients-1:0] lead_q, lead_d;
  logic [SizeW-1:0]      psize_q [MaxClients];
  logic [SizeW-1:0]      psize_d [MaxClients];
  logic [ScoreW-1:0]     pscore_q [MaxClients];
  logic [ScoreW-1:0]     pscore_d [MaxClients];
  logic [ScoreW-1:0]     sc_best_q, sc_best_d;
  logic [1:0]            sc_cnt_q, sc_cnt_d;
  logic [SlotW-1:0]      sc_idx_q, sc_idx_d;
  logic [SizeW-1:0]      sz_best_q, sz_best_d;
  logic [1:0]            sz_cnt_q, sz_cnt_d;
  logic [SlotW-1:0]      sz_idx_q, sz_idx_d;
  logic [SlotW-1:0]      w_q, w_d;
  logic [31:0]           tb_q, tb_d;
  logic [SlotW-1:0]      t_q, t_d;
  logic                  have_q, have_d;
  vote_e                 res_vote_q, res_vote_d;
  logic                  res_save_q, res_save_d;
  vote_e                 out_vote_q, out_vote_d;
  logic [SlotW-1:0]      out_slot_q, out_slot_d;

  // memory ports
  logic                     c_we, m_we;
  logic [SlotW-1:0]         c_raddr;
  logic [SlotW+PosW-1:0]    m_raddr;
  logic [ClientW-1:0]       crd_raw;
  client_t                  crd;
  logic [31:0]              mrd;

  // single-index reads of the small flop tables
  logic [SlotW-1:0]  cnt_ra, lv_ra, p_idx;
  logic [CntW-1:0]   cnt_rd;
  vote_e             lv_rd;
  logic [SizeW-1:0]  psize_rd;
  logic [ScoreW-1:0] pscore_rd;
  logic [SlotW-1:0]  jx, ix;
  logic              me_ring_eq;

  assign crd       = client_t'(crd_raw);
  assign cnt_rd    = cnt_q[cnt_ra];
  assign lv_rd     = lastv_q[lv_ra];
  assign psize_rd  = psize_q[p_idx];
  assign pscore_rd = pscore_q[p_idx];
  assign jx        = j_q[SlotW-1:0];
  assign ix        = i_q[SlotW-1:0];
  assign me_ring_eq = (crd.ring_node == me_rec_q.ring_node) &&
                      (crd.ring_seq == me_rec_q.ring_seq);

  lms_ram #(.Width(ClientW), .Depth(MaxClients)) u_client_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (in_slot),
    .wdata_i (in_rec),
    .raddr_i (c_raddr),
    .rdata_o (crd_raw)
  );

  lms_ram #(.Width(32), .Depth(MaxClients * MaxMembers)) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i ({in_slot, in_pos}),
    .wdata_i (in_mid),
    .raddr_i (m_raddr),
    .rdata_o (mrd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_slot_q, out_vote_q};

  // sequencer
  always_comb begin
    logic [ScoreW-1:0] inc;
    logic              add_en;
    state_d     = state_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    lastv_d     = lastv_q;
    out_valid_d = out_valid_q;
    me_d        = me_q;
    me_cnt_d    = me_cnt_q;
    me_lv_d     = me_lv_q;
    me_rec_d    = me_rec_q;
    j_d         = j_q;
    i_d         = i_q;
    k_d         = k_q;
    n_d         = n_q;
    j_node_d    = j_node_q;
    j_rnode_d   = j_rnode_q;
    j_rseq_d    = j_rseq_q;
    j_heur_d    = j_heur_q;
    lead_d      = lead_q;
    psize_d     = psize_q;
    pscore_d    = pscore_q;
    sc_best_d   = sc_best_q;
    sc_cnt_d    = sc_cnt_q;
    sc_idx_d    = sc_idx_q;
    sz_best_d   = sz_best_q;
    sz_cnt_d    = sz_cnt_q;
    sz_idx_d    = sz_idx_q;
    w_d         = w_q;
    tb_d        = tb_q;
    t_d         = t_q;
    have_d      = have_q;
    res_vote_d  = res_vote_q;
    res_save_d  = res_save_q;
    out_vote_d  = out_vote_q;
    out_slot_d  = out_slot_q;
    c_we        = 1'b0;
    m_we        = 1'b0;
    c_raddr     = jx;
    m_raddr     = {me_q, k_q[PosW-1:0]};
    cnt_ra      = jx;
    lv_ra       = jx;
    p_idx       = jx;
    add_en      = 1'b0;

    // output register drains
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        cnt_ra = in_slot;
        lv_ra  = in_slot;
        if (accept) begin
          unique case (s_axis_tuser)
            OP_CLIENT: begin
              c_we = 1'b1;
              if (!used_q[in_slot]) begin
                lastv_d[in_slot] = VOTE_NEW;
              end
              used_d[in_slot] = in_used;
              cnt_d[in_slot]  = (in_cnt > CntW'(MaxMembers)) ? CntW'(MaxMembers)
                                                             : in_cnt[CntW-1:0];
            end
            OP_MEMBER: begin
              m_we = 1'b1;
            end
            OP_DECIDE: begin
              me_d     = in_slot;
              me_cnt_d = cnt_rd;
              me_lv_d  = lv_rd;
              state_d  = ST_ME_RD;
            end
            default: ;
          endcase
        end
      end
      ST_ME_RD: begin
        c_raddr = me_q;
        state_d = ST_ME_LAT;
      end
      ST_ME_LAT: begin
        me_rec_d = crd;
        j_d      = '0;
        state_d  = ST_PD_SEL;
      end
      // peer scan: a listed peer on another ring forces wait
      ST_PD_SEL: begin
        if (j_q == JW'(MaxClients)) begin
          state_d = ST_PB_INIT;
        end else if (used_q[jx] && jx != me_q) begin
          c_raddr = jx;
          state_d = ST_PD_LAT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_PD_LAT: begin
        j_node_d = crd.node;
        k_d      = '0;
        if (me_ring_eq) begin
          j_d     = j_q + 1'b1;
          state_d = ST_PD_SEL;
        end else begin
          state_d = ST_PD_M1;
        end
      end
      ST_PD_M1: begin
        if (k_q >= me_cnt_q) begin
          k_d     = '0;
          state_d = ST_PD_M2;
        end else begin
          m_raddr = {me_q, k_q[PosW-1:0]};
          state_d = ST_PD_M1C;
        end
      end
      ST_PD_M1C: begin
        if (mrd == j_node_q) begin
          res_vote_d = VOTE_WAIT;
          res_save_d = 1'b1;
          state_d    = ST_FIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_PD_M1;
        end
      end
      ST_PD_M2: begin
        if (k_q >= cnt_rd) begin
          j_d     = j_q + 1'b1;
          state_d = ST_PD_SEL;
        end else begin
          m_raddr = {jx, k_q[PosW-1:0]};
          state_d = ST_PD_M2C;
        end
      end
      ST_PD_M2C: begin
        if (mrd == me_rec_q.node) begin
          res_vote_d = VOTE_WAIT;
          res_save_d = 1'b1;
          state_d    = ST_FIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_PD_M2;
        end
      end
      // partitions, each kept at the slot of its first client
      ST_PB_INIT: begin
        lead_d = '0;
        for (int p = 0; p < MaxClients; p++) begin
          psize_d[p]  = '0;
          pscore_d[p] = '0;
        end
        n_d     = '0;
        j_d     = '0;
        state_d = ST_PB_SEL;
      end
      ST_PB_SEL: begin
        if (j_q == JW'(MaxClients)) begin
          state_d = ST_PB_DONE;
        end else if (used_q[jx]) begin
          c_raddr = jx;
          state_d = ST_PB_LAT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_PB_LAT: begin
        if (crd.ring_seq == 64'd0) begin
          j_d     = j_q + 1'b1;
          state_d = ST_PB_SEL;
        end else begin
          j_rnode_d = crd.ring_node;
          j_rseq_d  = crd.ring_seq;
          j_heur_d  = crd.heur;
          i_d       = '0;
          state_d   = ST_PB_ISEL;
        end
      end
      ST_PB_ISEL: begin
        if (i_q == j_q) begin
          lead_d[jx] = 1'b1;
          n_d        = n_q + 1'b1;
          add_en     = 1'b1;
          j_d        = j_q + 1'b1;
          state_d    = ST_PB_SEL;
        end else if (lead_q[ix]) begin
          c_raddr = ix;
          state_d = ST_PB_ILAT;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_PB_ILAT: begin
        p_idx = ix;
        if (crd.ring_node == j_rnode_q && crd.ring_seq == j_rseq_q) begin
          add_en  = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = ST_PB_SEL;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_PB_ISEL;
        end
      end
      ST_PB_DONE: begin
        j_d      = '0;
        sc_cnt_d = '0;
        sz_cnt_d = '0;
        res_save_d = 1'b1;
        if (n_q == '0) begin
          res_vote_d = VOTE_WAIT;
          state_d    = ST_FIN;
        end else if (n_q == JW'(1)) begin
          res_vote_d = VOTE_ACK;
          state_d    = ST_FIN;
        end else if (me_lv_q == VOTE_NEW) begin
          state_d = ST_NC_SEL;
        end else begin
          state_d = ST_UM_SCAN;
        end
      end
      // newcomer: nack if a client on another ring holds an ack
      ST_NC_SEL: begin
        if (j_q == JW'(MaxClients)) begin
          j_d     = '0;
          state_d = ST_UM_SCAN;
        end else if (used_q[jx] && jx != me_q && lv_rd == VOTE_ACK) begin
          c_raddr = jx;
          state_d = ST_NC_LAT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_NC_LAT: begin
        if (!me_ring_eq) begin
          res_vote_d = VOTE_NACK;
          res_save_d = 1'b0;
          state_d    = ST_FIN;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_NC_SEL;
        end
      end
      // best score and largest size with tie counts
      ST_UM_SCAN: begin
        if (j_q == JW'(MaxClients)) begin
          state_d = ST_UM_DONE;
        end else begin
          if (lead_q[jx]) begin
            if (sc_cnt_q == '0 || pscore_rd > sc_best_q) begin
              sc_best_d = pscore_rd;
              sc_cnt_d  = 2'd1;
              sc_idx_d  = jx;
            end else if (pscore_rd == sc_best_q) begin
              sc_cnt_d = 2'd2;
            end
            if (sz_cnt_q == '0 || psize_rd > sz_best_q) begin
              sz_best_d = psize_rd;
              sz_cnt_d  = 2'd1;
              sz_idx_d  = jx;
            end else if (psize_rd == sz_best_q) begin
              sz_cnt_d = 2'd2;
            end
          end
          j_d = j_q + 1'b1;
        end
      end
      ST_UM_DONE: begin
        if (sc_cnt_q == 2'd1) begin
          w_d     = sc_idx_q;
          state_d = ST_WIN_RD;
        end else if (sz_cnt_q == 2'd1) begin
          w_d     = sz_idx_q;
          state_d = ST_WIN_RD;
        end else begin
          state_d = ST_TB;
        end
      end
      ST_WIN_RD: begin
        c_raddr = w_q;
        state_d = ST_WIN_LAT;
      end
      ST_WIN_LAT: begin
        res_vote_d = me_ring_eq ? VOTE_ACK : VOTE_NACK;
        res_save_d = 1'b1;
        state_d    = ST_FIN;
      end
      // tie-break by the deciding client's mode
      ST_TB: begin
        res_save_d = 1'b1;
        unique case (tb_mode_e'(me_rec_q.tb_mode))
          TB_LOWEST, TB_HIGHEST: begin
            j_d     = '0;
            have_d  = 1'b0;
            tb_d    = '0;
            state_d = ST_TB_SEL;
          end
          TB_NOMINATED: begin
            res_vote_d = (me_rec_q.node == me_rec_q.tb_node) ? VOTE_ACK : VOTE_NACK;
            state_d    = ST_FIN;
          end
          TB_NONE: begin
            res_vote_d = VOTE_WAIT;
            res_save_d = 1'b0;
            state_d    = ST_FIN;
          end
        endcase
      end
      ST_TB_SEL: begin
        if (j_q == JW'(MaxClients)) begin
          state_d = ST_TB_END;
        end else if (used_q[jx]) begin
          c_raddr = jx;
          state_d = ST_TB_LAT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_TB_LAT: begin
        if (!have_q ||
            (me_rec_q.tb_mode == TB_LOWEST && crd.node < tb_q) ||
            (me_rec_q.tb_mode == TB_HIGHEST && crd.node > tb_q)) begin
          tb_d   = crd.node;
          t_d    = jx;
          have_d = 1'b1;
        end
        j_d     = j_q + 1'b1;
        state_d = ST_TB_SEL;
      end
      ST_TB_END: begin
        if (me_rec_q.node == tb_q) begin
          res_vote_d = VOTE_ACK;
          state_d    = ST_FIN;
        end else if (have_q) begin
          w_d     = t_q;
          state_d = ST_WIN_RD;
        end else begin
          res_vote_d = (me_rec_q.ring_node == 32'd0 && me_rec_q.ring_seq == 64'd0)
                       ? VOTE_ACK : VOTE_NACK;
          state_d    = ST_FIN;
        end
      end
      // hand the vote to the output register
      ST_FIN: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_vote_d  = res_vote_q;
          out_slot_d  = me_q;
          if (res_save_q) begin
            lastv_d[me_q] = res_vote_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // partition accumulate
    inc = (j_heur_q == HEUR_PASS) ? ScoreW'(2) :
          (j_heur_q == HEUR_FAIL) ? ScoreW'(0) : ScoreW'(1);
    if (add_en) begin
      psize_d[p_idx]  = psize_rd + 1'b1;
      pscore_d[p_idx] = pscore_rd + inc;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < MaxClients; c++) begin
        cnt_q[c]   <= '0;
        lastv_q[c] <= VOTE_NEW;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      lastv_q     <= lastv_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    me_q       <= me_d;
    me_cnt_q   <= me_cnt_d;
    me_lv_q    <= me_lv_d;
    me_rec_q   <= me_rec_d;
    j_q        <= j_d;
    i_q        <= i_d;
    k_q        <= k_d;
    n_q        <= n_d;
    j_node_q   <= j_node_d;
    j_rnode_q  <= j_rnode_d;
    j_rseq_q   <= j_rseq_d;
    j_heur_q   <= j_heur_d;
    lead_q     <= lead_d;
    psize_q    <= psize_d;
    pscore_q   <= pscore_d;
    sc_best_q  <= sc_best_d;
    sc_cnt_q   <= sc_cnt_d;
    sc_idx_q   <= sc_idx_d;
    sz_best_q  <= sz_best_d;
    sz_cnt_q   <= sz_cnt_d;
    sz_idx_q   <= sz_idx_d;
    w_q        <= w_d;
    tb_q       <= tb_d;
    t_q        <= t_d;
    have_q     <= have_d;
    res_vote_q <= res_vote_d;
    res_save_q <= res_save_d;
    out_vote_q <= out_vote_d;
    out_slot_q <= out_slot_d;
  end

`ifndef SYNTH
  // a saved vote is never the new marker
  a_save_not_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_valid_q && res_save_q) |-> res_vote_q != VOTE_NEW)
    else $error("saved vote is the new marker");

  // a decide item keeps the input closed until it finishes
  a_decide_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == OP_DECIDE) |=> !s_axis_tready)
    else $error("input reopened during decide");

  // partition count matches the leader flags
  a_part_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PB_DONE) |-> ($countones(lead_q) == n_q))
    else $error("partition count mismatch");
`endif

endmodule
`default_nettype wire

// File: hdl/lms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lms_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
